### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hw/rtl/cbbt_pkg.sv
// Package for the colour blob box tracker: payload types, register indexes, helpers.
// No dependencies.
package cbbt_pkg;

  localparam int unsigned FrameRowsDef = 240;
  localparam int unsigned FrameColsDef = 320;
  localparam int unsigned CfgW = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CntW = 17;
  localparam int unsigned SumW = 25;
  localparam int unsigned SqW = 33;
  localparam int unsigned BoxW = 12;
  localparam int unsigned FifoDepth = 4;

  typedef enum logic [CfgIdxW-1:0] {
    RegColorSel  = 3'd0,
    RegRedThr    = 3'd1,
    RegGreenThr  = 3'd2,
    RegBlueThr   = 3'd3,
    RegMinCount  = 3'd4,
    RegBorder    = 3'd5,
    RegPadding   = 3'd6,
    RegUnused    = 3'd7
  } reg_idx_e;

  localparam logic [1:0] SelRed   = 2'd1;
  localparam logic [1:0] SelGreen = 2'd2;
  localparam logic [1:0] SelBlue  = 2'd3;

  typedef struct packed {
    logic [15:0] pixel;
    logic [7:0]  row;
    logic [8:0]  col;
    logic        end_of_frame;
  } in_word_t;

  typedef struct packed {
    logic        detected;
    logic [16:0] matched_count;
    logic [7:0]  outer_row_start;
    logic [7:0]  outer_row_end;
    logic [8:0]  outer_col_start;
    logic [8:0]  outer_col_end;
    logic [7:0]  inner_row_start;
    logic [7:0]  inner_row_end;
    logic [8:0]  inner_col_start;
    logic [8:0]  inner_col_end;
  } out_word_t;

  // Front-to-back queue entry: a classified pixel.
  typedef struct packed {
    logic       hit;
    logic [7:0] row;
    logic [8:0] col;
    logic       eof;
  } cls_t;

  typedef struct packed {
    logic [1:0]    color_select;
    logic [5:0]    red_thr;
    logic [5:0]    green_thr;
    logic [5:0]    blue_thr;
    logic [CntW-1:0] min_count;
    logic [5:0]    border;
    logic [7:0]    padding;
  } cfg_t;

  typedef enum logic [2:0] {
    StAcc, StRowDiv, StColDiv, StSqrt, StBox, StOut
  } back_state_e;

endpackage

### hw/rtl/cbbt_front.sv
// Front end: colour classification of each pixel word against the thresholds.
// Depends on cbbt_pkg.
module cbbt_front (
  input  cbbt_pkg::in_word_t word_i,
  input  cbbt_pkg::cfg_t     cfg_i,
  output cbbt_pkg::cls_t     cls_o
);
  logic [4:0] r, b;
  logic [5:0] g;
  logic match;

  assign r = word_i.pixel[15:11];
  assign g = word_i.pixel[10:5];
  assign b = word_i.pixel[4:0];

  always_comb begin
    unique case (cfg_i.color_select)
      cbbt_pkg::SelRed: match = ({1'b0, r} > cfg_i.red_thr) && (g < cfg_i.green_thr)
                                && ({1'b0, b} < cfg_i.blue_thr);
      cbbt_pkg::SelGreen: match = (g > cfg_i.green_thr) && ({1'b0, r} < cfg_i.red_thr)
                                  && ({1'b0, b} < cfg_i.blue_thr);
      cbbt_pkg::SelBlue: match = ({1'b0, b} > cfg_i.blue_thr) && (g < cfg_i.green_thr)
                                 && ({1'b0, r} < cfg_i.red_thr);
      default: match = 1'b0;
    endcase
  end

  // Colour match only; the window test is done in the back end, in order
  // with the frame ends that move the window.
  assign cls_o.hit = match;
  assign cls_o.row = word_i.row;
  assign cls_o.col = word_i.col;
  assign cls_o.eof = word_i.end_of_frame;
endmodule

### hw/rtl/cbbt_fifo.sv
// Short queue of classified pixels between front and back.
// Depends on cbbt_pkg.
module cbbt_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cbbt_pkg::cls_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output cbbt_pkg::cls_t  data_o
);
  localparam int unsigned AW = $clog2(cbbt_pkg::FifoDepth);
  cbbt_pkg::cls_t mem_q [cbbt_pkg::FifoDepth];
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [AW:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(cbbt_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_comb begin
    wp_d = wp_q + AW'(push_i);
    rp_d = rp_q + AW'(pop_i);
    cnt_d = cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end
endmodule

### hw/rtl/cbbt_back.sv
// Back end: window test, accumulation, end-of-frame divide/sqrt sequencer,
// box history, result. Depends on cbbt_pkg.
module cbbt_back #(
  parameter int unsigned FrameRows = cbbt_pkg::FrameRowsDef,
  parameter int unsigned FrameCols = cbbt_pkg::FrameColsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cbbt_pkg::cfg_t                    cfg_i,
  input  logic                              empty_i,
  input  cbbt_pkg::cls_t                    cls_i,
  output logic                              pop_o,
  output logic                              valid_o,
  input  logic                              stall_i,
  output cbbt_pkg::out_word_t               data_o
);
  localparam int unsigned CntW = cbbt_pkg::CntW;
  localparam int unsigned SumW = cbbt_pkg::SumW;
  localparam int unsigned SqW  = cbbt_pkg::SqW;
  localparam int unsigned BoxW = cbbt_pkg::BoxW;
  // Dividend: square sum << 16 fits 49 bits; quotients fit in 33 bits.
  localparam int unsigned DvW  = SqW + 16;
  localparam int unsigned QW   = 34;
  localparam int unsigned MW   = 17; // centroid: coordinate < 512, 8 fraction bits
  localparam int unsigned RW   = 36; // sqrt result bits (var < 2^66 covered)
  localparam int unsigned VW   = 2 * RW;

  cbbt_pkg::back_state_e st_q, st_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] rsum_q, rsum_d, csum_q, csum_d;
  logic [SqW-1:0]  rsq_q, rsq_d, csq_q, csq_d;
  logic signed [BoxW-1:0] former_q [4], latter_q [4];
  logic signed [BoxW-1:0] win [4];

  // shared divider / sqrt iteration state
  logic [6:0]    step_q;
  logic          phase_q;      // 0: mean, 1: mean square
  logic          axis_q;       // 0: row, 1: col
  logic [DvW-1:0] dvd_q;
  logic [CntW:0]  rem_q;
  logic [DvW-1:0] quo_q;
  logic [QW-1:0]  mean_q;
  logic [VW-1:0]  var_q, sres_q, sbit_q;
  logic signed [15:0] bs_q [4];  // unclamped starts/ends: row s, col s, row e, col e

  logic          ovalid_q;
  cbbt_pkg::out_word_t odata_q, odata_d;

  localparam logic signed [BoxW-1:0] RowsS = BoxW'(FrameRows);
  localparam logic signed [BoxW-1:0] ColsS = BoxW'(FrameCols);

  function automatic logic signed [BoxW-1:0] clampb(input logic signed [BoxW+1:0] v,
                                                    input logic signed [BoxW-1:0] hi);
    logic signed [BoxW+1:0] r;
    begin
      r = v;
      if (v < 0) r = '0;
      else if (v > (BoxW+2)'(hi)) r = (BoxW+2)'(hi);
      return BoxW'(r);
    end
  endfunction

  function automatic logic signed [BoxW-1:0] sat12(input logic signed [15:0] v);
    begin
      if (v < -16'sd2048) return -12'sd2048;
      if (v > 16'sd2047) return 12'sd2047;
      return BoxW'(v);
    end
  endfunction

  function automatic logic [SumW-1:0] sadd_s(input logic [SumW-1:0] a, input logic [9:0] b);
    logic [SumW:0] s;
    begin
      s = {1'b0, a} + (SumW+1)'(b);
      return s[SumW] ? '1 : s[SumW-1:0];
    end
  endfunction

  function automatic logic [SqW-1:0] sadd_q(input logic [SqW-1:0] a, input logic [17:0] b);
    logic [SqW:0] s;
    begin
      s = {1'b0, a} + (SqW+1)'(b);
      return s[SqW] ? '1 : s[SqW-1:0];
    end
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      win[i] = clampb({latter_q[i][BoxW-1], latter_q[i], 1'b0} - (BoxW+2)'(former_q[i]),
                      (i % 2 == 0) ? RowsS : ColsS);
    end
  end

  // Window is clamped to [0, frame], so non-negative.
  logic in_win, hit;
  assign in_win = ($signed({4'd0, cls_i.row}) >= win[0])
               && ($signed({4'd0, cls_i.row}) <  win[2])
               && ($signed({3'd0, cls_i.col}) >= win[1])
               && ($signed({3'd0, cls_i.col}) <  win[3]);
  assign hit = cls_i.hit && in_win;

  // 9x9 squares are small enough to sit in the accumulate cycle
  logic [17:0] rr, cc;
  assign rr = 18'(cls_i.row) * 18'(cls_i.row);
  assign cc = 18'(cls_i.col) * 18'(cls_i.col);

  // result written this cycle; waits while the previous one is unread
  logic emit;
  assign emit = (st_q == cbbt_pkg::StBox) && !ovalid_q;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      cbbt_pkg::StAcc:
        if (!empty_i && cls_i.eof) st_d = cbbt_pkg::StRowDiv;
      cbbt_pkg::StRowDiv, cbbt_pkg::StColDiv:
        if (step_q == 7'(DvW - 1) && phase_q) st_d = cbbt_pkg::StSqrt;
      cbbt_pkg::StSqrt:
        if (sbit_q == '0) st_d = axis_q ? cbbt_pkg::StBox : cbbt_pkg::StColDiv;
      cbbt_pkg::StBox: if (!ovalid_q) st_d = cbbt_pkg::StOut;
      cbbt_pkg::StOut: st_d = cbbt_pkg::StAcc;
      default: st_d = cbbt_pkg::StAcc;
    endcase
  end

  // outputs
  always_comb begin
    pop_o = (st_q == cbbt_pkg::StAcc) && !empty_i;
  end

  // accumulators, saturating; cleared when the frame result is written
  always_comb begin
    cnt_d = cnt_q; rsum_d = rsum_q; csum_d = csum_q; rsq_d = rsq_q; csq_d = csq_q;
    if (pop_o && hit) begin
      cnt_d = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
      rsum_d = sadd_s(rsum_q, 10'(cls_i.row));
      csum_d = sadd_s(csum_q, 10'(cls_i.col));
      rsq_d = sadd_q(rsq_q, rr);
      csq_d = sadd_q(csq_q, cc);
    end
    if (emit) begin
      cnt_d = '0; rsum_d = '0; csum_d = '0; rsq_d = '0; csq_d = '0;
    end
  end

  logic found;
  assign found = (cnt_q > cfg_i.min_count) && (cnt_q != '0);

  // restoring-division step
  logic [CntW:0]  rem_sh;
  logic           ge;
  assign rem_sh = {rem_q[CntW-1:0], dvd_q[DvW-1]};
  assign ge = rem_sh >= {1'b0, cnt_q};

  // sqrt step
  logic [VW-1:0] trial;
  assign trial = sres_q + sbit_q;

  logic [2*MW-1:0] m2p;
  logic [VW-1:0]   m2;
  assign m2p = mean_q[MW-1:0] * mean_q[MW-1:0];
  assign m2 = VW'(m2p);

  // box arithmetic
  logic signed [15:0] bw, pw, st, en;
  logic [RW-1:0] root;
  assign bw = 16'(cfg_i.border);
  assign pw = 16'(cfg_i.padding);
  assign root = RW'(sres_q);
  always_comb begin
    logic signed [40:0] t;
    t = $signed({7'd0, mean_q}) - $signed({4'd0, root, 1'b0});
    st = 16'(t >>> 8) - bw - pw;
    en = st + 16'(root >> 6) + (bw <<< 1) + (pw <<< 1);
  end

  logic signed [BoxW+1:0] ls [4];
  always_comb begin
    for (int i = 0; i < 4; i++) ls[i] = (BoxW+2)'(sat12(bs_q[i]));
  end

  always_comb begin
    odata_d = '0;
    odata_d.matched_count = cnt_q;
    if (found) begin
      odata_d.detected = 1'b1;
      odata_d.outer_row_start = 8'(clampb(ls[0] + 14'(pw), RowsS));
      odata_d.outer_row_end   = 8'(clampb(ls[2] - 14'(pw), RowsS));
      odata_d.outer_col_start = 9'(clampb(ls[1] + 14'(pw), ColsS));
      odata_d.outer_col_end   = 9'(clampb(ls[3] - 14'(pw), ColsS));
      odata_d.inner_row_start = 8'(clampb(ls[0] + 14'(pw) + 14'(bw), RowsS));
      odata_d.inner_row_end   = 8'(clampb(ls[2] - 14'(pw) - 14'(bw), RowsS));
      odata_d.inner_col_start = 9'(clampb(ls[1] + 14'(pw) + 14'(bw), ColsS));
      odata_d.inner_col_end   = 9'(clampb(ls[3] - 14'(pw) - 14'(bw), ColsS));
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      cbbt_pkg::StAcc: begin
        step_q <= '0; phase_q <= 1'b0; axis_q <= 1'b0;
        rem_q <= '0;
        dvd_q <= DvW'({rsum_d, 8'd0});
      end
      cbbt_pkg::StRowDiv, cbbt_pkg::StColDiv: begin
        rem_q <= ge ? rem_sh - {1'b0, cnt_q} : rem_sh;
        quo_q <= {quo_q[DvW-2:0], ge};
        dvd_q <= {dvd_q[DvW-2:0], 1'b0};
        step_q <= step_q + 7'd1;
        if (step_q == 7'(DvW - 1)) begin
          step_q <= '0;
          rem_q <= '0;
          if (!phase_q) begin
            mean_q <= QW'({quo_q[DvW-2:0], ge});
            phase_q <= 1'b1;
            dvd_q <= axis_q ? {csq_q, 16'd0} : {rsq_q, 16'd0};
          end else begin
            sres_q <= '0;
            sbit_q <= VW'(1) << (VW - 2);
            var_q <= (VW'({quo_q[DvW-2:0], ge}) > m2) ? VW'({quo_q[DvW-2:0], ge}) - m2 : '0;
          end
        end
      end
      cbbt_pkg::StSqrt: begin
        // align the trial bit first, before any root bit is set
        if ((sbit_q > var_q) && (sres_q == '0)) begin
          sbit_q <= sbit_q >> 2;
        end else if (sbit_q != '0) begin
          if (var_q >= trial) begin
            var_q <= var_q - trial;
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end else begin
          bs_q[axis_q ? 1 : 0] <= st;
          bs_q[axis_q ? 3 : 2] <= en;
          axis_q <= 1'b1;
          phase_q <= 1'b0;
          dvd_q <= DvW'({csum_q, 8'd0});
        end
      end
      default: ;
    endcase
  end

  // set to the full frame at reset: the box history is control of the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cbbt_pkg::StAcc;
      cnt_q <= '0; rsum_q <= '0; csum_q <= '0; rsq_q <= '0; csq_q <= '0;
      for (int i = 0; i < 4; i++) begin
        former_q[i] <= (i % 2 == 0) ? ((i == 0) ? '0 : RowsS) : ((i == 1) ? '0 : ColsS);
        latter_q[i] <= (i % 2 == 0) ? ((i == 0) ? '0 : RowsS) : ((i == 1) ? '0 : ColsS);
      end
      ovalid_q <= 1'b0;
      odata_q <= '0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d; rsum_q <= rsum_d; csum_q <= csum_d; rsq_q <= rsq_d; csq_q <= csq_d;
      if (ovalid_q && !stall_i) ovalid_q <= 1'b0;
      if (emit) begin
        odata_q <= odata_d;
        if (found) begin
          for (int i = 0; i < 4; i++) begin
            former_q[i] <= latter_q[i];
            latter_q[i] <= sat12(bs_q[i]);
          end
        end else begin
          for (int i = 0; i < 4; i++) begin
            former_q[i] <= (i == 0 || i == 1) ? '0 : ((i == 2) ? RowsS : ColsS);
            latter_q[i] <= (i == 0 || i == 1) ? '0 : ((i == 2) ? RowsS : ColsS);
          end
        end
        ovalid_q <= 1'b1;
      end
    end
  end

  assign valid_o = ovalid_q;
  assign data_o  = odata_q;
endmodule

### hw/rtl/color_blob_box_tracker_unit.sv
// Colour blob box tracker top level: config registers, front end, queue, back end.
// Depends on cbbt_pkg, cbbt_front, cbbt_fifo, cbbt_back.
//
// Use: pixel words enter on in_valid_i / in_stall_o, one per clock while the
// queue has room, in raster order with end_of_frame on the last pixel.
// The front end tests each word's colour against the thresholds; the word
// then waits in a four-entry queue. The back end pops one word a cycle while
// it is accumulating and the queue holds one, checks it against the search
// window predicted from the box history and accumulates counts and sums, so
// every word sees the boxes of all frames that ended before it.
// On an end-of-frame word the back end runs a shared bit-serial divider
// (four quotients) and a two-bit-a-step square root per axis; the result
// word is then registered. Meanwhile no pixel leaves the queue and in_stall_o
// rises once it fills.
// The result word waits in an output register on out_valid_o until
// out_stall_i is low; the back end goes back to pixels without waiting, and
// only a later frame end that finds the register still full waits for it.
// Reset clears the sums, sets both history boxes to the full frame and loads
// the register defaults. Config writes go through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user makes them only while the block is idle (not enforced).
module color_blob_box_tracker_unit #(
  parameter int unsigned FrameRows = cbbt_pkg::FrameRowsDef,
  parameter int unsigned FrameCols = cbbt_pkg::FrameColsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbbt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbbt_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cbbt_pkg::in_word_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cbbt_pkg::out_word_t           out_data_o
);
  cbbt_pkg::cfg_t cfg_q;
  cbbt_pkg::cls_t cls_in, cls_out;
  logic full, empty, pop, push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_select <= cbbt_pkg::SelRed;
      cfg_q.red_thr      <= 6'd26;
      cfg_q.green_thr    <= 6'd33;
      cfg_q.blue_thr     <= 6'd17;
      cfg_q.min_count    <= 17'd50;
      cfg_q.border       <= 6'd2;
      cfg_q.padding      <= 8'd20;
    end else if (cfg_we_i) begin
      unique case (cbbt_pkg::reg_idx_e'(cfg_idx_i))
        cbbt_pkg::RegColorSel: cfg_q.color_select <= cfg_wdata_i[1:0];
        cbbt_pkg::RegRedThr:   cfg_q.red_thr      <= cfg_wdata_i[5:0];
        cbbt_pkg::RegGreenThr: cfg_q.green_thr    <= cfg_wdata_i[5:0];
        cbbt_pkg::RegBlueThr:  cfg_q.blue_thr     <= cfg_wdata_i[5:0];
        cbbt_pkg::RegMinCount: cfg_q.min_count    <= cfg_wdata_i;
        cbbt_pkg::RegBorder:   cfg_q.border       <= cfg_wdata_i[5:0];
        cbbt_pkg::RegPadding:  cfg_q.padding      <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Colour test only; the user keeps thresholds static while words are in flight.
  cbbt_front u_front (
    .word_i(in_data_i), .cfg_i(cfg_q), .cls_o(cls_in)
  );

  assign in_stall_o = full;
  assign push = in_valid_i && !full;

  cbbt_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(cls_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(cls_out)
  );

  cbbt_back #(.FrameRows(FrameRows), .FrameCols(FrameCols)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .empty_i(empty), .cls_i(cls_out), .pop_o(pop),
    .valid_o(out_valid_o), .stall_i(out_stall_i), .data_o(out_data_o)
  );
endmodule

### hw/rtl/cbbt_checker.sv
// Port-level checker for the tracker top level, with its bind.
// Depends on cbbt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cbbt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cbbt_pkg::out_word_t out_data_o
);
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped")
  `ASSERT_IMPL(a_nodet_zero, clk_i, rst_ni, out_valid_o && !out_data_o.detected, out_data_o.outer_row_end == '0 && out_data_o.inner_col_end == '0, "undetected box not zero")
  `ASSERT_IMPL(a_ring_order, clk_i, rst_ni, out_valid_o && out_data_o.detected, out_data_o.outer_row_start <= out_data_o.inner_row_start, "inner ring outside outer")
endmodule

bind color_blob_box_tracker_unit cbbt_checker u_cbbt_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_data_o
);
